// File: sv/cbq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbq_pkg
// Shared widths, coefficient ROM contents and helpers for the biquad cascade.
// ---------------------------------------------------------------------------
package cbq_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SIG_W    = 40;
  localparam int COEF_W   = 24;
  localparam int ACC_W    = 64;
  localparam int HALF_W   = SIG_W / 2;

  localparam int TAPS_PER_STAGE  = 3;
  localparam int WORDS_PER_STAGE = TAPS_PER_STAGE + 2;

  localparam int DEF_STAGES          = 4;
  localparam int DEF_COEF_FRAC_BITS  = 22;
  localparam int DEF_STATE_FRAC_BITS = 16;

  localparam int DESIGN_STAGES = 4;
  localparam int DESIGN_FRAC   = 30;

  // Word order within a section
  localparam int W_B0 = 0;
  localparam int W_B1 = 1;
  localparam int W_B2 = 2;
  localparam int W_A1 = 3;
  localparam int W_A2 = 4;

  localparam logic signed [ACC_W-1:0] SIG_MAX  = 64'sd549755813887;
  localparam logic signed [ACC_W-1:0] SIG_MIN  = -64'sd549755813888;
  localparam logic signed [ACC_W-1:0] COEF_MAX = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] COEF_MIN = -64'sd8388608;

  // Designed sections in Q2.30: b0, b1, b2, a1, a2
  localparam logic signed [31:0] DESIGN_Q30 [DESIGN_STAGES*WORDS_PER_STAGE] = '{
    32'sd1071125,    32'sd1071125,    32'sd0,          -32'sd978078064,  32'sd0,
    32'sd1073741824, -32'sd1678152825, 32'sd1073741824, -32'sd1973331733, 32'sd936757797,
    32'sd1073741824, -32'sd1950226269, 32'sd1073741824, -32'sd2002199475, 32'sd1009895658,
    32'sd1073741824, -32'sd1995102310, 32'sd1073741824, -32'sd2026270286, 32'sd1056897543
  };

  typedef struct packed {
    logic                    valid;
    logic signed [SIG_W-1:0] data;
  } cbq_sig_t;

  // Round a design word to the chosen fraction width and clamp to 24 bits;
  // sections past the design pass their input through.
  function automatic logic signed [COEF_W-1:0] rom_word(input int stage, input int k,
                                                        input int frac);
    logic signed [ACC_W-1:0] q30;
    logic signed [ACC_W-1:0] half;
    logic signed [ACC_W-1:0] v;
    int                      sh;
    sh = DESIGN_FRAC - frac;
    if (stage < DESIGN_STAGES) begin
      q30 = ACC_W'(DESIGN_Q30[stage*WORDS_PER_STAGE + k]);
    end else if (k == W_B0) begin
      q30 = 64'sd1 <<< DESIGN_FRAC;
    end else begin
      q30 = 64'sd0;
    end
    half = (sh > 0) ? (64'sd1 <<< (sh - 1)) : 64'sd0;
    v = (q30 + half) >>> sh;
    if (v > COEF_MAX) v = COEF_MAX;
    if (v < COEF_MIN) v = COEF_MIN;
    return v[COEF_W-1:0];
  endfunction

  function automatic logic signed [SIG_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SIG_MAX) c = SIG_MAX;
    if (v < SIG_MIN) c = SIG_MIN;
    return c[SIG_W-1:0];
  endfunction

endpackage

// File: sv/cascaded_biquad_iir_filter_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cascaded_biquad_iir_filter_top
// Fixed-coefficient cascade of direct-form-II biquad sections for 16-bit audio.
// ---------------------------------------------------------------------------
// Each signed 16-bit item enters as Q24.16 and runs through STAGES biquad
// sections in series, one cell per section, each cell holding its own two
// delay words (cleared at reset) and Q2.22 coefficients from a built-in ROM.
// A cell forms its five coefficient products one at a time on a split
// 24x40 multiplier, each product passing through a multiply state and then
// a recombine-and-accumulate state, before a hand-off state. out_valid is
// registered and rises once the last section's result is loaded into the
// output register. Cells work as a pipeline, so a new item is taken once the
// first section has handed on the previous one, while later sections still
// work on earlier items. in_stall is high while the first cell is busy. The
// result is the last section's output truncated toward zero and clipped to
// 16 bits; out_saturated flags a clipped item. Internal overflow saturates
// to 40 bits silently. A result register lets the chain keep working while
// the output side stalls.
// ---------------------------------------------------------------------------
module cascaded_biquad_iir_filter_top #(
  parameter int STAGES          = cbq_pkg::DEF_STAGES,
  parameter int COEF_FRAC_BITS  = cbq_pkg::DEF_COEF_FRAC_BITS,
  parameter int STATE_FRAC_BITS = cbq_pkg::DEF_STATE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [cbq_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cbq_pkg::SAMPLE_W-1:0] out_filtered,
  output logic                                out_saturated
);

  localparam int SW = cbq_pkg::SIG_W;
  localparam int QW = cbq_pkg::SAMPLE_W;
  localparam logic signed [SW:0] OUT_MAX  = (SW+1)'(32767);
  localparam logic signed [SW:0] OUT_MIN  = -(SW+1)'(32768);
  localparam logic signed [SW:0] TRUNC_BIAS = (SW+1)'((64'sd1 <<< STATE_FRAC_BITS) - 1);

  cbq_pkg::cbq_sig_t   link [STAGES+1];
  logic                rdy  [STAGES+1];

  logic                out_valid_r, out_valid_nxt;
  logic signed [QW-1:0] sample_r, sample_nxt;
  logic                sat_r, sat_nxt;
  logic                out_free;

  logic signed [SW:0]  y_ext;
  logic signed [SW:0]  y_int;

  // Scale the sample up to the internal signal format
  assign link[0]  = '{valid: in_valid, data: (SW'(in_sample_in) <<< STATE_FRAC_BITS)};
  assign in_stall = !rdy[0];

  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_cell
      cbq_cell #(
        .STAGE_IDX     (g),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .x_in     (link[g]),
        .in_ready (rdy[g]),
        .y_out    (link[g+1]),
        .out_ready(rdy[g+1])
      );
    end
  endgenerate

  // Output register may load when empty or being drained this cycle
  assign out_free     = !out_valid_r || !out_stall;
  assign rdy[STAGES]  = out_free;

  // Truncate toward zero: bias negatives up before the arithmetic shift
  assign y_ext = (SW+1)'(link[STAGES].data);
  assign y_int = $signed(y_ext + (y_ext[SW] ? TRUNC_BIAS : '0)) >>> STATE_FRAC_BITS;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    sat_nxt       = sat_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (link[STAGES].valid && out_free) begin
      out_valid_nxt = 1'b1;
      if (y_int > OUT_MAX) begin
        sample_nxt = QW'(OUT_MAX);
        sat_nxt    = 1'b1;
      end else if (y_int < OUT_MIN) begin
        sample_nxt = QW'(OUT_MIN);
        sat_nxt    = 1'b1;
      end else begin
        sample_nxt = y_int[QW-1:0];
        sat_nxt    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold while stalled, no reset
  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    sat_r    <= sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = sample_r;
  assign out_saturated  = sat_r;

endmodule

// File: sv/cbq_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbq_cell
// One direct-form-II biquad section with its two delay words and a
// split 24x40 multiply-accumulate sequenced one product at a time.
// ---------------------------------------------------------------------------
module cbq_cell #(
  parameter int STAGE_IDX     = 0,
  parameter int COEF_FRAC_BITS = cbq_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cbq_pkg::cbq_sig_t x_in,
  output logic              in_ready,
  output cbq_pkg::cbq_sig_t y_out,
  input  logic              out_ready
);

  localparam int SW = cbq_pkg::SIG_W;
  localparam int CW = cbq_pkg::COEF_W;
  localparam int AW = cbq_pkg::ACC_W;
  localparam int HW = cbq_pkg::HALF_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Product order: feedback first, then feed-forward
  localparam logic [2:0] STEP_A1 = 3'd0;
  localparam logic [2:0] STEP_A2 = 3'd1;
  localparam logic [2:0] STEP_B0 = 3'd2;
  localparam logic [2:0] STEP_B1 = 3'd3;
  localparam logic [2:0] STEP_B2 = 3'd4;

  localparam logic signed [CW-1:0] C_B0 = cbq_pkg::rom_word(STAGE_IDX, cbq_pkg::W_B0, COEF_FRAC_BITS);
  localparam logic signed [CW-1:0] C_B1 = cbq_pkg::rom_word(STAGE_IDX, cbq_pkg::W_B1, COEF_FRAC_BITS);
  localparam logic signed [CW-1:0] C_B2 = cbq_pkg::rom_word(STAGE_IDX, cbq_pkg::W_B2, COEF_FRAC_BITS);
  localparam logic signed [CW-1:0] C_A1 = cbq_pkg::rom_word(STAGE_IDX, cbq_pkg::W_A1, COEF_FRAC_BITS);
  localparam logic signed [CW-1:0] C_A2 = cbq_pkg::rom_word(STAGE_IDX, cbq_pkg::W_A2, COEF_FRAC_BITS);

  logic [1:0]               state_r, state_nxt;
  logic [2:0]               step_r, step_nxt;
  logic signed [AW-1:0]     acc_r, acc_nxt;
  logic signed [SW-1:0]     w0_r, w0_nxt;
  logic signed [SW-1:0]     w1_r, w1_nxt;
  logic signed [SW-1:0]     w2_r, w2_nxt;
  logic signed [SW-1:0]     y_r, y_nxt;
  logic signed [CW+HW:0]    pl_r, pl_nxt;
  logic signed [CW+HW-1:0]  ph_r, ph_nxt;

  logic signed [CW-1:0]     coef_sel;
  logic signed [SW-1:0]     op_sel;
  logic signed [AW-1:0]     prod_full;
  logic signed [AW-1:0]     prod;
  logic signed [AW-1:0]     acc_sum;
  logic                     take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = (state_r == S_DONE) && out_ready;
  assign y_out    = '{valid: (state_r == S_DONE), data: y_r};

  always_comb begin
    case (step_r)
      STEP_A1: begin coef_sel = C_A1; op_sel = w1_r; end
      STEP_A2: begin coef_sel = C_A2; op_sel = w2_r; end
      STEP_B0: begin coef_sel = C_B0; op_sel = w0_r; end
      STEP_B1: begin coef_sel = C_B1; op_sel = w1_r; end
      STEP_B2: begin coef_sel = C_B2; op_sel = w2_r; end
      default: begin coef_sel = '0;   op_sel = '0;   end
    endcase
  end

  // Recombine the two partial products, floor-shift, then accumulate
  assign prod_full = (AW'(ph_r) <<< HW) + AW'(pl_r);
  assign prod      = prod_full >>> COEF_FRAC_BITS;
  assign acc_sum   = (step_r == STEP_A1 || step_r == STEP_A2) ? (acc_r - prod)
                                                              : (acc_r + prod);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    w0_nxt    = w0_r;
    w1_nxt    = w1_r;
    w2_nxt    = w2_r;
    y_nxt     = y_r;
    pl_nxt    = pl_r;
    ph_nxt    = ph_r;
    case (state_r)
      S_IDLE: begin
        if (x_in.valid) begin
          acc_nxt   = AW'(x_in.data);
          step_nxt  = STEP_A1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pl_nxt    = (CW+HW+1)'(coef_sel * $signed({1'b0, op_sel[HW-1:0]}));
        ph_nxt    = (CW+HW)'(coef_sel * $signed(op_sel[SW-1:HW]));
        state_nxt = S_ACC;
      end
      S_ACC: begin
        step_nxt  = step_r + 3'd1;
        state_nxt = S_MUL;
        if (step_r == STEP_A2) begin
          w0_nxt  = cbq_pkg::sat40(acc_sum);
          acc_nxt = '0;
        end else if (step_r == STEP_B2) begin
          y_nxt     = cbq_pkg::sat40(acc_sum);
          w2_nxt    = w1_r;
          w1_nxt    = w0_r;
          state_nxt = S_DONE;
        end else begin
          acc_nxt = acc_sum;
        end
      end
      S_DONE: begin
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_A1;
      w1_r    <= '0;
      w2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      w1_r    <= w1_nxt;
      w2_r    <= w2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w0_r  <= w0_nxt;
    y_r   <= y_nxt;
    pl_r  <= pl_nxt;
    ph_r  <= ph_nxt;
  end

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_ready) |=> (state_r == S_DONE && $stable(y_r)))
    else $error("section result dropped while downstream busy");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_ACC) |-> (step_r <= STEP_B2))
    else $error("section step counter out of range");

  a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ACC) |=> ($stable(w1_r) && $stable(w2_r)))
    else $error("delay words changed outside the final accumulate");

endmodule
